// ===== hdl/gsa_pkg.sv =====
// shared types and constants of the generational slot allocator
package gsa_pkg;

	localparam int SLOTS_DEF    = 256;
	localparam int GEN_BITS_DEF = 16;
	localparam int QUEUE_DEPTH  = 2;

	localparam int FUNC_W   = 2;
	localparam int INDEX_W  = 8;
	localparam int HGEN_W   = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ALLOC = 2'd0,
		FUNC_FREE  = 2'd1,
		FUNC_CHECK = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_EMPTY   = 2'd1,
		STATUS_INVALID = 2'd2
	} status_t;

	// classified command handed from front to back
	typedef struct packed {
		func_t               op;
		logic                in_range;
		logic [INDEX_W-1:0]  idx;
		logic [HGEN_W-1:0]   hgen;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [INDEX_W-1:0]  index;
		logic [HGEN_W-1:0]   gen;
		logic [COUNT_W-1:0]  count;
	} res_t;

endpackage

// ===== hdl/generational_slot_allocator.sv =====
// top level of the generational slot allocator
// path from input transfer to result: command queue, back end sequencer, result queue;
// pool-empty, out-of-range and clear are answered from idle; free and validate after a
// generation read; allocate after a stack read, then a generation read. the back end
// takes the next item once the last is answered and results have room; clear sweeps both tables.
// reset: async active low; a sweep of both tables follows, during which full stays high.
module generational_slot_allocator import gsa_pkg::*; #(
	parameter int SLOTS    = SLOTS_DEF,
	parameter int GEN_BITS = GEN_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [FUNC_W-1:0]   func,
	input  logic [INDEX_W-1:0]  slot_index,
	input  logic [HGEN_W-1:0]   handle_generation,
	output logic                empty,
	input  logic                pop,
	output logic [STATUS_W-1:0] status,
	output logic [INDEX_W-1:0]  granted_index,
	output logic [HGEN_W-1:0]   granted_generation,
	output logic [COUNT_W-1:0]  live_count
);

	cmd_t cmd_in, cmd_out;
	logic cmd_push, cmd_full, cmd_empty, cmd_pop;
	res_t res_in, res_out;
	logic res_push, res_full;
	logic sweep_busy;

	gsa_front #(
		.SLOTS (SLOTS)
	) u_front (
		.push              (push),
		.full              (full),
		.func              (func),
		.slot_index        (slot_index),
		.handle_generation (handle_generation),
		.sweep_busy        (sweep_busy),
		.cmd_push          (cmd_push),
		.cmd               (cmd_in),
		.cmd_full          (cmd_full)
	);

	gsa_fifo #(
		.W     ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	gsa_back #(
		.SLOTS    (SLOTS),
		.GEN_BITS (GEN_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_out),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res_in),
		.sweep_busy (sweep_busy)
	);

	gsa_fifo #(
		.W     ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign status             = res_out.status;
	assign granted_index      = res_out.index;
	assign granted_generation = res_out.gen;
	assign live_count         = res_out.count;

endmodule

// ===== hdl/gsa_fifo.sv =====
// small register queue used between the parts of the allocator
module gsa_fifo import gsa_pkg::*; #(
	parameter int W     = 1,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/gsa_front.sv =====
// front end: takes requests, decodes and range-checks them for the back end
module gsa_front import gsa_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic               push,
	output logic               full,
	input  logic [FUNC_W-1:0]  func,
	input  logic [INDEX_W-1:0] slot_index,
	input  logic [HGEN_W-1:0]  handle_generation,
	input  logic               sweep_busy,
	output logic               cmd_push,
	output cmd_t               cmd,
	input  logic               cmd_full
);

	// no transfer while the slot tables are being swept
	assign full     = cmd_full | sweep_busy;
	assign cmd_push = push & ~full;

	always_comb begin
		cmd.op       = func_t'(func);
		cmd.in_range = (32'(slot_index) < 32'(SLOTS));
		cmd.idx      = slot_index;
		cmd.hgen     = handle_generation;
	end

endmodule

// ===== hdl/gsa_back.sv =====
// back end: free-index stack, generation table and sequencer
module gsa_back import gsa_pkg::*; #(
	parameter int SLOTS    = SLOTS_DEF,
	parameter int GEN_BITS = GEN_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_empty,
	output logic cmd_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res,
	output logic sweep_busy
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CMP_W = (GEN_BITS > HGEN_W) ? GEN_BITS : HGEN_W;

	typedef enum logic [3:0] {
		ST_SWEEP = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_STACK = 4'b0100,
		ST_GEN   = 4'b1000
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   top_q, top_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [IDX_W-1:0]   sweep_q, sweep_d;
	logic [IDX_W-1:0]   slot_q, slot_d;
	cmd_t               cur_q, cur_d;

	// stack of free indices
	logic [IDX_W-1:0]   stk_mem_q [SLOTS];
	logic [IDX_W-1:0]   stk_rd_q;
	logic               stk_we, stk_ren;
	logic [IDX_W-1:0]   stk_waddr, stk_raddr, stk_wdata;

	// live bit on top of the generation
	logic [GEN_BITS:0]  gen_mem_q [SLOTS];
	logic [GEN_BITS:0]  gen_rd_q;
	logic               gen_we, gen_ren;
	logic [IDX_W-1:0]   gen_waddr, gen_raddr;
	logic [GEN_BITS:0]  gen_wdata;

	logic               rd_live;
	logic [GEN_BITS-1:0] rd_gen, next_gen;

	assign rd_live    = gen_rd_q[GEN_BITS];
	assign rd_gen     = gen_rd_q[GEN_BITS-1:0];
	assign next_gen   = rd_gen + 1'b1;
	assign sweep_busy = (state_q == ST_SWEEP);

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem_q[stk_waddr] <= stk_wdata;
		end
		if (stk_ren) begin
			stk_rd_q <= stk_mem_q[stk_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (gen_we) begin
			gen_mem_q[gen_waddr] <= gen_wdata;
		end
		if (gen_ren) begin
			gen_rd_q <= gen_mem_q[gen_raddr];
		end
	end

	always_comb begin
		state_d    = state_q;
		top_d      = top_q;
		count_d    = count_q;
		sweep_d    = sweep_q;
		slot_d     = slot_q;
		cur_d      = cur_q;
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		res.status = STATUS_OK;
		res.index  = '0;
		res.gen    = '0;
		res.count  = COUNT_W'(count_q);
		stk_we     = 1'b0;
		stk_ren    = 1'b0;
		stk_waddr  = sweep_q;
		stk_raddr  = IDX_W'(top_q - 1'b1);
		stk_wdata  = IDX_W'(SLOTS - 1) - sweep_q;
		gen_we     = 1'b0;
		gen_ren    = 1'b0;
		gen_waddr  = sweep_q;
		gen_raddr  = IDX_W'(cmd.idx);
		gen_wdata  = '0;

		case (state_q)
			ST_SWEEP: begin
				stk_we = 1'b1;
				gen_we = 1'b1;
				if (sweep_q == IDX_W'(SLOTS - 1)) begin
					state_d = ST_IDLE;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end
			ST_IDLE: begin
				// one result slot is reserved before a command is taken
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					cur_d   = cmd;
					case (cmd.op)
						FUNC_CLEAR: begin
							res_push  = 1'b1;
							res.count = '0;
							top_d     = CNT_W'(SLOTS);
							count_d   = '0;
							sweep_d   = '0;
							state_d   = ST_SWEEP;
						end
						FUNC_ALLOC: begin
							if (top_q == '0) begin
								res_push   = 1'b1;
								res.status = STATUS_EMPTY;
							end else begin
								stk_ren = 1'b1;
								top_d   = top_q - 1'b1;
								state_d = ST_STACK;
							end
						end
						default: begin
							if (!cmd.in_range) begin
								res_push   = 1'b1;
								res.status = STATUS_INVALID;
							end else begin
								gen_ren = 1'b1;
								slot_d  = IDX_W'(cmd.idx);
								state_d = ST_GEN;
							end
						end
					endcase
				end
			end
			ST_STACK: begin
				gen_ren   = 1'b1;
				gen_raddr = stk_rd_q;
				slot_d    = stk_rd_q;
				state_d   = ST_GEN;
			end
			ST_GEN: begin
				res_push = 1'b1;
				state_d  = ST_IDLE;
				case (cur_q.op)
					FUNC_ALLOC: begin
						gen_we    = 1'b1;
						gen_waddr = slot_q;
						gen_wdata = {1'b1, next_gen};
						count_d   = count_q + 1'b1;
						res.index = INDEX_W'(slot_q);
						res.gen   = HGEN_W'(next_gen);
						res.count = COUNT_W'(count_d);
					end
					FUNC_FREE: begin
						if (!rd_live || top_q == CNT_W'(SLOTS)) begin
							res.status = STATUS_INVALID;
						end else begin
							gen_we    = 1'b1;
							gen_waddr = slot_q;
							gen_wdata = {1'b0, rd_gen};
							stk_we    = 1'b1;
							stk_waddr = IDX_W'(top_q);
							stk_wdata = slot_q;
							top_d     = top_q + 1'b1;
							if (count_q != '0) begin
								count_d = count_q - 1'b1;
							end
							res.index = INDEX_W'(slot_q);
							res.gen   = HGEN_W'(rd_gen);
							res.count = COUNT_W'(count_d);
						end
					end
					default: begin
						if (rd_live && (CMP_W'(rd_gen) == CMP_W'(cur_q.hgen))) begin
							res.index = INDEX_W'(slot_q);
							res.gen   = HGEN_W'(rd_gen);
						end else begin
							res.status = STATUS_INVALID;
						end
					end
				endcase
			end
			default: begin
				state_d = ST_SWEEP;
				sweep_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			top_q   <= CNT_W'(SLOTS);
			count_q <= '0;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			count_q <= count_d;
			sweep_q <= sweep_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
		cur_q  <= cur_d;
	end

endmodule
